// ===== src/swpd_pkg.sv =====
// ----------------------------------------------------------------------------
// swpd_pkg: shared types and constants of the work partition dispatcher
// request and status codes, register indexes, sequencer states and the
// command/status bundles of the shared arithmetic unit
// ----------------------------------------------------------------------------
package swpd_pkg;

	localparam int DEF_MAX_DEVICES = 4;
	localparam int DEF_GRAIN       = 128;

	localparam int DATA_W    = 32;
	localparam int SHARE_W   = 16;
	localparam int CNT_W     = 3;
	localparam int DEV_W     = 2;
	localparam int REQ_W     = 2;
	localparam int STS_W     = 2;
	localparam int CFG_IDX_W = 3;

	// divisor width of the shared unit, wide enough for the largest grain
	localparam int DEF_DVW = 17;

	localparam int MUL_STEPS = 16;
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = 6;

	typedef enum logic [REQ_W-1:0] {
		REQ_START = 2'd0,
		REQ_FETCH = 2'd1,
		REQ_DONE  = 2'd2
	} req_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_BAD_DEV = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL  = 3'd0,
		CFG_MODE   = 3'd1,
		CFG_COUNT  = 3'd2,
		CFG_SHARE0 = 3'd3,
		CFG_SHARE1 = 3'd4,
		CFG_SHARE2 = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    go;
		alu_op_t op;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} alu_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHARE,
		S_SHARE_W,
		S_GRAIN,
		S_GRAIN_W,
		S_COMMIT,
		S_LAST
	} state_t;

endpackage

// ===== src/swpd_alu.sv =====
// ----------------------------------------------------------------------------
// swpd_alu: shared bit-serial multiply / divide unit
// one 34-bit add/subtract per cycle while busy; multiply returns (opa*opm)>>16,
// divide returns quotient and remainder of opa/dvs
// ----------------------------------------------------------------------------
module swpd_alu import swpd_pkg::*; #(
	parameter int DVW = DEF_DVW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_cmd_t          cmd,
	input  logic [DATA_W-1:0] opa,
	input  logic [SHARE_W-1:0] opm,
	input  logic [DVW-1:0]    dvs,
	output alu_sts_t          sts,
	output logic [DATA_W-1:0] quo,
	output logic [DVW-1:0]    rmd
);

	logic              busy_q;
	logic              fin_q;
	alu_op_t           op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] sh_q;
	logic [DATA_W-1:0] mcand_q;
	logic [DVW-1:0]    dvs_q;

	logic [DVW:0]      trial;
	logic [DATA_W:0]   add_a;
	logic [DATA_W:0]   add_b;
	logic              sub;
	logic [DATA_W+1:0] sum;
	logic              fits;
	logic              last_step;

	always_comb begin
		trial = {hi_q[DVW-1:0], sh_q[DATA_W-1]};
		if (op_q == OP_MUL) begin
			add_a = {1'b0, hi_q};
			add_b = sh_q[0] ? {1'b0, mcand_q} : '0;
			sub   = 1'b0;
		end else begin
			add_a = (DATA_W+1)'(trial);
			add_b = (DATA_W+1)'(dvs_q);
			sub   = 1'b1;
		end
		sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (DATA_W+2)'(sub);
		// a carry out of the subtract means the trial remainder holds the divisor
		fits = sum[DATA_W+1];
		if (op_q == OP_MUL) begin
			last_step = (cnt_q == STEP_W'(MUL_STEPS - 1));
		end else begin
			last_step = (cnt_q == STEP_W'(DIV_STEPS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else if (cmd.go) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			op_q   <= cmd.op;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (last_step) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			hi_q    <= '0;
			sh_q    <= (cmd.op == OP_MUL) ? DATA_W'(opm) : opa;
			mcand_q <= opa;
			dvs_q   <= dvs;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				// shift-add, multiplier bits leave at the bottom
				hi_q <= sum[DATA_W:1];
				sh_q <= {sum[0], sh_q[DATA_W-1:1]};
			end else if (fits) begin
				hi_q <= DATA_W'(sum[DVW-1:0]);
				sh_q <= {sh_q[DATA_W-2:0], 1'b1};
			end else begin
				hi_q <= DATA_W'(trial[DVW-1:0]);
				sh_q <= {sh_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.fin  = fin_q;
	assign quo      = (op_q == OP_MUL) ? hi_q : sh_q;
	assign rmd      = hi_q[DVW-1:0];

endmodule

// ===== src/static_work_partition_dispatcher.sv =====
// ----------------------------------------------------------------------------
// static_work_partition_dispatcher: splits a work range among devices
// a start request carves total_size into per-device chunks; later requests
// hand out chunks and track completions until every device is done
//
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------
// request  | start / busy              | req_type, dev_sel
// result   | done (one-cycle strobe)   | status, granted, chunk_size,
//          |                           | chunk_offset, first_done, all_done
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// work and completion requests: result strobe in the cycle after acceptance,
//   busy never rises
// start request: busy while the shares are computed one device after another
//   on the bit-serial multiply/divide unit, a multiply for proportional split
//   and a divide for even split; a second divide per device takes the
//   remainder when the grain is not a power of two
// reset clears flags and counters and loads the configuration defaults;
//   chunk table entries in use are rewritten by every start, never read before one
// the result has no back-pressure: done is high for exactly one cycle
// ----------------------------------------------------------------------------
module static_work_partition_dispatcher import swpd_pkg::*; #(
	parameter int MAX_DEVICES = DEF_MAX_DEVICES,
	parameter int GRAIN       = DEF_GRAIN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 start,
	output logic                 busy,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [DEV_W-1:0]     dev_sel,
	// result channel
	output logic                 done,
	output logic [STS_W-1:0]     status,
	output logic                 granted,
	output logic [DATA_W-1:0]    chunk_size,
	output logic [DATA_W-1:0]    chunk_offset,
	output logic                 first_done,
	output logic                 all_done,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int IDX_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int DVW_G  = $clog2(GRAIN + 1);
	localparam int DVW    = (DVW_G > CNT_W) ? DVW_G : CNT_W;
	localparam bit GRAIN_POW2 = ((GRAIN & (GRAIN - 1)) == 0);
	localparam logic [DATA_W-1:0] GRAIN_MASK = ~(DATA_W'(GRAIN - 1));
	localparam logic [DVW-1:0]    GRAIN_DVS  = DVW'(GRAIN);
	localparam logic [CNT_W-1:0]  MAX_N      = CNT_W'(MAX_DEVICES);

	// configuration registers
	logic [DATA_W-1:0]  total_q;
	logic               mode_q;
	logic [CNT_W-1:0]   dcount_q;
	logic [SHARE_W-1:0] share0_q;
	logic [SHARE_W-1:0] share1_q;
	logic [SHARE_W-1:0] share2_q;

	// sequencer and bookkeeping
	state_t             state_q;
	state_t             state_d;
	logic [IDX_W-1:0]   i_q;
	logic [CNT_W-1:0]   n_q;
	logic [DATA_W-1:0]  rem_q;
	logic [DATA_W-1:0]  acc_q;
	logic [DATA_W-1:0]  raw_q;
	logic [DATA_W-1:0]  give_q;

	// chunk tables, undefined until the first start
	logic [DATA_W-1:0]  psize_q [MAX_DEVICES];
	logic [DATA_W-1:0]  poff_q  [MAX_DEVICES];

	logic [MAX_DEVICES-1:0] given_q;
	logic [MAX_DEVICES-1:0] fdone_q;
	logic [CNT_W-1:0]   wc_q;
	logic               started_q;

	// result registers
	logic               done_q;
	status_t            status_q;
	logic               granted_q;
	logic [DATA_W-1:0]  csize_q;
	logic [DATA_W-1:0]  coff_q;
	logic               first_q;
	logic               all_q;

	// shared unit hookup
	alu_cmd_t           alu_cmd;
	alu_sts_t           alu_sts;
	logic [DATA_W-1:0]  alu_opa;
	logic [SHARE_W-1:0] alu_opm;
	logic [DVW-1:0]     alu_dvs;
	logic [DATA_W-1:0]  alu_quo;
	logic [DVW-1:0]     alu_rmd;

	logic               take;
	logic               take_start;
	logic               take_req;
	logic [CNT_W-1:0]   eff_n;
	logic [IDX_W-1:0]   dev_idx;
	logic [IDX_W-1:0]   last_idx;
	logic               dev_live;
	logic               cfg_wr;

	// per-request decisions
	status_t            rq_status;
	logic               rq_grant;
	logic               rq_first;
	logic               rq_all;
	logic [CNT_W-1:0]   wc_next;

	assign take       = start && !busy;
	assign take_start = take && (req_type == REQ_START);
	assign take_req   = take && (req_type != REQ_START);
	assign cfg_ready  = (state_q == S_IDLE);
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign dev_idx    = IDX_W'(dev_sel);
	assign last_idx   = IDX_W'(n_q - CNT_W'(1));
	// devices past the count of the last start hold empty chunks
	assign dev_live   = (CNT_W'(dev_idx) < n_q);

	// device count clamped into 1..MAX_DEVICES
	always_comb begin
		if (dcount_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (dcount_q > MAX_N) begin
			eff_n = MAX_N;
		end else begin
			eff_n = dcount_q;
		end
	end

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			mode_q   <= 1'b1;
			dcount_q <= CNT_W'(1);
			share0_q <= SHARE_W'(32768);
			share1_q <= SHARE_W'(32768);
			share2_q <= SHARE_W'(32768);
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOTAL:  total_q  <= cfg_data;
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_COUNT:  dcount_q <= cfg_data[CNT_W-1:0];
				CFG_SHARE0: share0_q <= cfg_data[SHARE_W-1:0];
				CFG_SHARE1: share1_q <= cfg_data[SHARE_W-1:0];
				CFG_SHARE2: share2_q <= cfg_data[SHARE_W-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// ------------------------------------------------------- shared unit feed
	always_comb begin
		case (CNT_W'(i_q))
			CNT_W'(0): alu_opm = share0_q;
			CNT_W'(1): alu_opm = share1_q;
			default:   alu_opm = share2_q;
		endcase
		// second pass divides the raw share by the grain to get its remainder
		if (state_q == S_GRAIN) begin
			alu_opa = raw_q;
			alu_dvs = GRAIN_DVS;
		end else begin
			alu_opa = rem_q;
			alu_dvs = DVW'(n_q);
		end
	end

	swpd_alu #(
		.DVW (DVW)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.opa    (alu_opa),
		.opm    (alu_opm),
		.dvs    (alu_dvs),
		.sts    (alu_sts),
		.quo    (alu_quo),
		.rmd    (alu_rmd)
	);

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		alu_cmd = '{go: 1'b0, op: OP_MUL};
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (take_start) begin
					// a single device just takes everything
					state_d = (eff_n == CNT_W'(1)) ? S_LAST : S_SHARE;
				end
			end
			S_SHARE: begin
				alu_cmd = '{go: 1'b1, op: (mode_q ? OP_DIV : OP_MUL)};
				state_d = S_SHARE_W;
			end
			S_SHARE_W: begin
				if (alu_sts.fin) begin
					state_d = GRAIN_POW2 ? S_COMMIT : S_GRAIN;
				end
			end
			S_GRAIN: begin
				alu_cmd = '{go: 1'b1, op: OP_DIV};
				state_d = S_GRAIN_W;
			end
			S_GRAIN_W: begin
				if (alu_sts.fin) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				// next device is the last one when i+2 reaches the count
				state_d = ((CNT_W'(i_q) + CNT_W'(2)) == n_q) ? S_LAST : S_SHARE;
			end
			S_LAST: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------ request decisions
	always_comb begin
		rq_status = ST_OK;
		rq_grant  = 1'b0;
		rq_first  = 1'b0;
		rq_all    = 1'b0;
		wc_next   = (wc_q != '0) ? (wc_q - CNT_W'(1)) : '0;
		if (req_type != REQ_FETCH && req_type != REQ_DONE) begin
			rq_status = ST_REFUSED;
		end else if ({1'b0, dev_sel} >= eff_n) begin
			rq_status = ST_BAD_DEV;
		end else if (!started_q) begin
			rq_status = ST_REFUSED;
		end else if (req_type == REQ_FETCH) begin
			if (given_q[dev_idx]) begin
				rq_status = ST_REFUSED;
			end else begin
				rq_grant = 1'b1;
			end
		end else begin
			if (!given_q[dev_idx]) begin
				rq_status = ST_REFUSED;
			end else if (!fdone_q[dev_idx]) begin
				rq_first = 1'b1;
				rq_all   = (wc_next == '0);
			end
			// a repeated completion is ok with nothing flagged
		end
	end

	// ---------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			n_q       <= '0;
			given_q   <= '0;
			fdone_q   <= '0;
			wc_q      <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_LAST) || take_req;
			if (take_start) begin
				i_q <= '0;
				n_q <= eff_n;
			end
			if (state_q == S_COMMIT) begin
				i_q <= i_q + IDX_W'(1);
			end
			if (state_q == S_LAST) begin
				// restart semantics: all flags cleared, every device working
				given_q   <= '0;
				fdone_q   <= '0;
				wc_q      <= n_q;
				started_q <= 1'b1;
			end
			if (take_req) begin
				if (rq_grant) begin
					given_q[dev_idx] <= 1'b1;
				end
				if (rq_first) begin
					fdone_q[dev_idx] <= 1'b1;
					wc_q             <= wc_next;
				end
			end
		end
	end

	// ------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (take_start) begin
			rem_q <= total_q;
			acc_q <= '0;
		end
		if (state_q == S_SHARE_W && alu_sts.fin) begin
			raw_q  <= alu_quo;
			give_q <= alu_quo & GRAIN_MASK;
		end
		if (state_q == S_GRAIN_W && alu_sts.fin) begin
			give_q <= raw_q - DATA_W'(alu_rmd);
		end
		if (state_q == S_COMMIT) begin
			psize_q[i_q] <= give_q;
			poff_q[i_q]  <= acc_q;
			acc_q        <= acc_q + give_q;
			rem_q        <= rem_q - give_q;
		end
		if (state_q == S_LAST) begin
			// the last device takes whatever is left
			psize_q[last_idx] <= rem_q;
			poff_q[last_idx]  <= acc_q;
			status_q  <= ST_OK;
			granted_q <= 1'b0;
			csize_q   <= '0;
			coff_q    <= '0;
			first_q   <= 1'b0;
			all_q     <= 1'b0;
		end
		if (take_req) begin
			status_q  <= rq_status;
			granted_q <= rq_grant;
			csize_q   <= (rq_grant && dev_live) ? psize_q[dev_idx] : '0;
			coff_q    <= (rq_grant && dev_live) ? poff_q[dev_idx] : '0;
			first_q   <= rq_first;
			all_q     <= rq_all;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign granted      = granted_q;
	assign chunk_size   = csize_q;
	assign chunk_offset = coff_q;
	assign first_done   = first_q;
	assign all_done     = all_q;

	// ------------------------------------------------------------ assertions
	// a result never shows up while a partition is still being computed
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a grant always carries an ok status
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted) |-> (status == ST_OK))
		else $error("grant with non-ok status");

	// all_done only on a first completion
	a_all_first: assert property (@(posedge clk) disable iff (!arst_n)
		(done && all_done) |-> first_done)
		else $error("all_done without first completion");

	// the shared unit finishes only while the sequencer waits for it
	a_alu_fin: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.fin |-> (state_q == S_SHARE_W || state_q == S_GRAIN_W))
		else $error("arithmetic unit finished outside a wait state");

	// working count never exceeds the device limit
	a_wc_range: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= MAX_N)
		else $error("working count out of range");

endmodule

// ===== sim/static_work_partition_dispatcher_tb.sv =====
// ----------------------------------------------------------------------------
// static_work_partition_dispatcher_tb: self-checking bench for the dispatcher
// a local model carves the work range and tracks grants and completions;
// directed requests cover the corner cases, then random partition rounds
// with noise requests and random idling check every reply field by field
// ----------------------------------------------------------------------------
module static_work_partition_dispatcher_tb;
	import swpd_pkg::*;

	localparam int MAX_DEV         = DEF_MAX_DEVICES;
	localparam int GRAIN           = DEF_GRAIN;
	// request code outside the defined set, must be refused
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	// no handshake of any kind for this many cycles ends the run
	localparam int IDLE_LIMIT      = 2000;
	// settle time at the end, longer than the slowest start request
	localparam int DRAIN_CYCLES    = 150;
	localparam int RANDOM_REQUESTS = 1900;

	typedef struct packed {
		status_t             status;
		logic                granted;
		logic [DATA_W-1:0]   chunk_size;
		logic [DATA_W-1:0]   chunk_offset;
		logic                first_done;
		logic                all_done;
	} dispatch_reply_t;

	// dut ports, every input known from time zero
	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	logic                 busy;
	logic [REQ_W-1:0]     req_type     = '0;
	logic [DEV_W-1:0]     dev_sel      = '0;
	logic                 done;
	logic [STS_W-1:0]     status;
	logic                 granted;
	logic [DATA_W-1:0]    chunk_size;
	logic [DATA_W-1:0]    chunk_offset;
	logic                 first_done;
	logic                 all_done;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_TOTAL;
	logic [DATA_W-1:0]    cfg_data     = '0;

	// local copy of the registers, at their reset values
	logic [DATA_W-1:0]    cfg_total    = '0;
	logic                 cfg_mode     = 1'b1;
	logic [CNT_W-1:0]     cfg_count    = 3'd1;
	logic [SHARE_W-1:0]   cfg_share [3] = '{default: 16'd32768};

	// local copy of the partition state
	logic [DATA_W-1:0]    chunk_len [MAX_DEV];
	logic [DATA_W-1:0]    chunk_base [MAX_DEV];
	logic                 chunk_taken [MAX_DEV]    = '{default: 1'b0};
	logic                 chunk_finished [MAX_DEV] = '{default: 1'b0};
	int unsigned          devices_working = 0;
	logic                 partition_live  = 1'b0;

	dispatch_reply_t      pending_replies [$];
	int unsigned          errors      = 0;
	int unsigned          idle_cycles = 0;
	// set for a stretch of the random part: no gaps on either channel
	logic                 steady      = 1'b0;

	static_work_partition_dispatcher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.dev_sel      (dev_sel),
		.done         (done),
		.status       (status),
		.granted      (granted),
		.chunk_size   (chunk_size),
		.chunk_offset (chunk_offset),
		.first_done   (first_done),
		.all_done     (all_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// device count register as the block uses it: 0 acts as 1, above max clamps
	function automatic int unsigned active_devices(logic [CNT_W-1:0] count);
		if (count == 0)
			return 1;
		if (count > MAX_DEV)
			return MAX_DEV;
		return 32'(count);
	endfunction

	// walk the devices in order, each but the last takes a grain-aligned share
	// of what is still unassigned; the last one gets the remainder
	function automatic void carve_work();
		int unsigned       n;
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] give;
		logic [63:0]       raw;
		n    = active_devices(cfg_count);
		left = cfg_total;
		base = '0;
		for (int i = 0; i < MAX_DEV; i++) begin
			chunk_len[i]  = '0;
			chunk_base[i] = '0;
		end
		for (int unsigned i = 0; i + 1 < n; i++) begin
			// proportional split uses a q0.16 fraction, even split an exact divide
			if (!cfg_mode)
				raw = (64'(cfg_share[i % 3]) * 64'(left)) >> SHARE_W;
			else
				raw = 64'(left) / 64'(n);
			give          = DATA_W'((raw / GRAIN) * GRAIN);
			chunk_len[i]  = give;
			chunk_base[i] = base;
			base          = base + give;
			left          = left - give;
		end
		chunk_len[n-1]  = left;
		chunk_base[n-1] = base;
	endfunction

	function automatic dispatch_reply_t dispatch_reply(logic [REQ_W-1:0] req,
			logic [DEV_W-1:0] dev);
		dispatch_reply_t r;
		r        = '0;
		r.status = ST_OK;
		if (req == REQ_START) begin
			// start or restart: new partition, all flags cleared
			carve_work();
			chunk_taken     = '{default: 1'b0};
			chunk_finished  = '{default: 1'b0};
			devices_working = active_devices(cfg_count);
			partition_live  = 1'b1;
		end else if (req == REQ_UNKNOWN) begin
			r.status = ST_REFUSED;
		end else if (dev >= active_devices(cfg_count)) begin
			// device range check wins over every refusal but the unknown code
			r.status = ST_BAD_DEV;
		end else if (!partition_live) begin
			r.status = ST_REFUSED;
		end else if (req == REQ_FETCH) begin
			if (chunk_taken[dev]) begin
				r.status = ST_REFUSED;
			end else begin
				chunk_taken[dev] = 1'b1;
				r.granted        = 1'b1;
				r.chunk_size     = chunk_len[dev];
				r.chunk_offset   = chunk_base[dev];
			end
		end else begin
			// completion: refused without a grant, silent when repeated
			if (!chunk_taken[dev]) begin
				r.status = ST_REFUSED;
			end else if (!chunk_finished[dev]) begin
				chunk_finished[dev] = 1'b1;
				r.first_done        = 1'b1;
				if (devices_working > 0)
					devices_working--;
				if (devices_working == 0)
					r.all_done = 1'b1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// checking: replies against the oldest prediction, then new requests and
	// register writes update the local model, all on pre-edge values
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		dispatch_reply_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					$error("reply strobe with no request outstanding");
					errors++;
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, granted);
						errors++;
					end
					if (chunk_size !== want.chunk_size) begin
						$error("chunk_size: expected %0d, got %0d",
							want.chunk_size, chunk_size);
						errors++;
					end
					if (chunk_offset !== want.chunk_offset) begin
						$error("chunk_offset: expected %0d, got %0d",
							want.chunk_offset, chunk_offset);
						errors++;
					end
					if (first_done !== want.first_done) begin
						$error("first_done: expected %0d, got %0d",
							want.first_done, first_done);
						errors++;
					end
					if (all_done !== want.all_done) begin
						$error("all_done: expected %0d, got %0d", want.all_done, all_done);
						errors++;
					end
				end
			end
			if (start && !busy)
				pending_replies = {pending_replies, dispatch_reply(req_type, dev_sel)};
			if (cfg_valid && cfg_ready) begin
				// registers narrower than the data word keep only the low bits
				case (cfg_index)
					CFG_TOTAL:  cfg_total    = cfg_data;
					CFG_MODE:   cfg_mode     = cfg_data[0];
					CFG_COUNT:  cfg_count    = cfg_data[CNT_W-1:0];
					CFG_SHARE0: cfg_share[0] = cfg_data[SHARE_W-1:0];
					CFG_SHARE1: cfg_share[1] = cfg_data[SHARE_W-1:0];
					CFG_SHARE2: cfg_share[2] = cfg_data[SHARE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// watchdog: any handshake on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("no handshake for %0d cycles", IDLE_LIMIT);
				$display("static_work_partition_dispatcher_tb failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one request; start stays high after acceptance so back-to-back requests
	// never lower and raise it in the same step
	task automatic send_request(logic [REQ_W-1:0] req, logic [DEV_W-1:0] dev);
		if (!steady)
			while ($urandom_range(99) < 15) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start     <= 1'b1;
		req_type  <= req;
		dev_sel   <= dev;
		do
			@(posedge clk);
		while (busy);
	endtask

	// stop requesting and wait for every outstanding reply
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] data);
		if (!steady)
			while ($urandom_range(99) < 15) begin
				cfg_valid <= 1'b0;
				@(posedge clk);
			end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// full register set, only called with no reply outstanding
	task automatic program_dispatcher(logic [DATA_W-1:0] total, logic [DATA_W-1:0] mode,
			logic [DATA_W-1:0] count, logic [DATA_W-1:0] s0, logic [DATA_W-1:0] s1,
			logic [DATA_W-1:0] s2);
		write_reg(CFG_TOTAL, total);
		write_reg(CFG_MODE, mode);
		write_reg(CFG_COUNT, count);
		write_reg(CFG_SHARE0, s0);
		write_reg(CFG_SHARE1, s1);
		write_reg(CFG_SHARE2, s2);
		cfg_valid <= 1'b0;
	endtask

	// share register value: zero, one, full scale or anything, junk above
	function automatic logic [DATA_W-1:0] pick_share();
		logic [SHARE_W-1:0] s;
		case ($urandom_range(5))
			0:       s = '0;
			1:       s = 16'd1;
			2:       s = '1;
			default: s = SHARE_W'($urandom_range(65535));
		endcase
		return {16'($urandom()), s};
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset config has one device: requests before any start are refused,
	// out-of-range device and unknown code too
	task automatic test_before_start();
		send_request(REQ_FETCH, 2'd0);
		send_request(REQ_DONE, 2'd0);
		send_request(REQ_FETCH, 2'd3);
		send_request(REQ_UNKNOWN, 2'd2);
		drain_results();
	endtask

	// even split over four devices, with refusals and repeats mixed in
	task automatic test_even_split();
		program_dispatcher(32'd1000, 32'd1, 32'd4, 32'd32768, 32'd32768, 32'd32768);
		send_request(REQ_START, 2'd0);
		// completion before the chunk was handed out
		send_request(REQ_DONE, 2'd1);
		for (int d = 0; d < MAX_DEV; d++)
			send_request(REQ_FETCH, DEV_W'(d));
		// second fetch of the same chunk
		send_request(REQ_FETCH, 2'd2);
		// last of these raises all_done
		for (int d = 0; d < MAX_DEV; d++)
			send_request(REQ_DONE, DEV_W'(d));
		// repeated completion, silent
		send_request(REQ_DONE, 2'd3);
		drain_results();
	endtask

	// full-range total, extreme shares including zero, count above max, restart
	task automatic test_raw_split_extremes();
		program_dispatcher(32'hFFFF_FFFF, 32'd0, 32'd7, 32'd65535, 32'd0, 32'd1);
		send_request(REQ_START, 2'd0);
		for (int d = 0; d < MAX_DEV; d++)
			send_request(REQ_FETCH, DEV_W'(d));
		// restart while live: flags clear, device 1 may fetch again
		send_request(REQ_START, 2'd3);
		send_request(REQ_FETCH, 2'd1);
		drain_results();
	endtask

	// count register of zero behaves as a single device
	task automatic test_count_zero();
		program_dispatcher(32'd5, 32'd1, 32'd0, 32'd32768, 32'd32768, 32'd32768);
		send_request(REQ_START, 2'd0);
		send_request(REQ_FETCH, 2'd0);
		send_request(REQ_DONE, 2'd0);
		send_request(REQ_FETCH, 2'd1);
		drain_results();
	endtask

	// random rounds: new registers, a start, then each device fetches and
	// completes in random order, with noise requests (bad devices, repeats,
	// unknown codes, restarts) mixed in
	task automatic test_random_rounds();
		int unsigned        sent;
		int unsigned        n;
		int unsigned        left;
		int unsigned        d;
		int                 stage [MAX_DEV];
		logic [DATA_W-1:0]  total;
		logic [CNT_W-1:0]   count;
		logic [REQ_W-1:0]   req;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			steady = (sent >= 700 && sent < 1000);
			case ($urandom_range(4))
				0:       total = '0;
				1:       total = '1;
				2:       total = $urandom_range(1023);
				3:       total = $urandom_range(1 << 20);
				default: total = $urandom();
			endcase
			if ($urandom_range(99) < 85)
				count = CNT_W'($urandom_range(1, MAX_DEV));
			else
				count = CNT_W'($urandom_range(7));
			program_dispatcher(total, {31'($urandom()), 1'($urandom_range(1))},
				{29'($urandom()), count}, pick_share(), pick_share(), pick_share());

			n = active_devices(count);
			send_request(REQ_START, DEV_W'($urandom_range(3)));
			sent++;
			for (int i = 0; i < MAX_DEV; i++)
				stage[i] = 0;
			left = n;
			while (left != 0) begin
				if ($urandom_range(99) < 80) begin
					// next step of some device that has not finished
					d = $urandom_range(n - 1);
					while (stage[d] == 2)
						d = (d + 1) % n;
					if (stage[d] == 0) begin
						send_request(REQ_FETCH, DEV_W'(d));
						stage[d] = 1;
					end else begin
						send_request(REQ_DONE, DEV_W'(d));
						stage[d] = 2;
						left--;
					end
				end else begin
					req = REQ_W'($urandom_range(3));
					send_request(req, DEV_W'($urandom_range(3)));
					if (req == REQ_START) begin
						// a restart sends every device back to the beginning
						for (int i = 0; i < MAX_DEV; i++)
							stage[i] = 0;
						left = n;
					end
				end
				sent++;
			end
			drain_results();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_start();
		test_even_split();
		test_raw_split_extremes();
		test_count_zero();
		test_random_rounds();

		drain_results();
		// any stray reply strobe in this window is flagged by the checker
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("static_work_partition_dispatcher_tb passed");
		else
			$display("static_work_partition_dispatcher_tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/swpd_pkg.sv
src/swpd_alu.sv
src/static_work_partition_dispatcher.sv
sim/static_work_partition_dispatcher_tb.sv
